// File: rtl/core/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types and constants for the SHA-256 message hash core.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_word;

    typedef struct packed {
        logic [63:0] digest_part;
        logic [1:0]  part_index;
        logic        last_part;
    } t_out_word;

    // control from sequencer to round unit
    typedef struct packed {
        logic       load;    // copy hash words into working registers
        logic       step;    // run one round
        logic [5:0] round;
        logic       fold;    // add working registers into hash words
        logic       init;    // reload initial hash values
    } t_rnd_ctl;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        begin
            case (r)
                6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
                6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
                6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
                6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
                6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

endpackage

// File: rtl/core/sha256_round.sv
// ----------------------------------------------------------------------------
// sha256_round
// Shared round unit: working registers a..h and chained hash words; one compression
// round per cycle while step is high, with load, fold and reload of the hash.
// ----------------------------------------------------------------------------
module sha256_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha256_pkg::t_rnd_ctl i_ctl,
    input  logic [31:0]          i_w,
    output logic [255:0]         o_hash
);

    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [31:0] r_hw [8];
    logic [31:0] bs0, bs1, ch, mj, t1;

    // round function
    always_comb begin
        bs1 = {r_e[5:0], r_e[31:6]} ^ {r_e[10:0], r_e[31:11]} ^ {r_e[24:0], r_e[31:25]};
        ch  = (r_e & r_f) ^ (~r_e & r_g);
        t1  = r_h + bs1 + ch + sha256_pkg::round_k(i_ctl.round) + i_w;
        bs0 = {r_a[1:0], r_a[31:2]} ^ {r_a[12:0], r_a[31:13]} ^ {r_a[21:0], r_a[31:22]};
        mj  = (r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c);
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= 32'h0; r_b <= 32'h0; r_c <= 32'h0; r_d <= 32'h0;
            r_e <= 32'h0; r_f <= 32'h0; r_g <= 32'h0; r_h <= 32'h0;
        end else if (i_ctl.load) begin
            r_a <= r_hw[0]; r_b <= r_hw[1]; r_c <= r_hw[2]; r_d <= r_hw[3];
            r_e <= r_hw[4]; r_f <= r_hw[5]; r_g <= r_hw[6]; r_h <= r_hw[7];
        end else if (i_ctl.step) begin
            r_h <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
            r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + bs0 + mj;
        end
    end

    // chained hash words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int i = 0; i < 8; i++) begin
                r_hw[i] <= sha256_pkg::INIT_HASH[255 - 32*i -: 32];
            end
        end else if (i_ctl.fold) begin
            r_hw[0] <= r_hw[0] + r_a; r_hw[1] <= r_hw[1] + r_b;
            r_hw[2] <= r_hw[2] + r_c; r_hw[3] <= r_hw[3] + r_d;
            r_hw[4] <= r_hw[4] + r_e; r_hw[5] <= r_hw[5] + r_f;
            r_hw[6] <= r_hw[6] + r_g; r_hw[7] <= r_hw[7] + r_h;
        end
    end

    assign o_hash = {r_hw[0], r_hw[1], r_hw[2], r_hw[3],
                     r_hw[4], r_hw[5], r_hw[6], r_hw[7]};

endmodule

// File: rtl/core/sha256_message_hash_core.sv
// ----------------------------------------------------------------------------
// sha256_message_hash_core
// SHA-256 over a byte stream, digest delivered as four 64-bit words.
// ----------------------------------------------------------------------------
// Input channel: one message byte per word (i_in_valid / o_in_stall). A word
// with byte_present low and end_of_message low is dropped. end_of_message
// closes the message; a byte on the same word is taken first.
// A byte that does not fill a block does not stall the input. A byte that
// fills a block stalls the input through load, 64 rounds on the shared
// round unit and fold. An end word then runs a single final block (pad,
// length, load, rounds, fold), or two when the length does not fit, and
// emits four digest words, 0 to 3, on the output channel (o_out_valid /
// i_out_stall); each is held on the output while stalled, and the input
// stays stalled until the last digest word is taken. The hash words then
// reload the initial values for the next message.
// The single round unit runs 64 rounds per 64-byte block, and the input
// stays stalled meanwhile, so no new byte is taken until the block is folded.
// Reset (synchronous, active low) clears the control, the counters and the
// working registers and loads the initial hash words; the schedule store
// has no reset, every entry is written before it is read.
// ----------------------------------------------------------------------------
module sha256_message_hash_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sha256_pkg::t_in_word  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sha256_pkg::t_out_word o_out_data
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_ROUND = 7'b0000100,
        ST_FOLD  = 7'b0001000,
        ST_PAD   = 7'b0010000,
        ST_LEN   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    t_state      r_state, n_state;
    logic [5:0]  r_cnt;        // bytes pending in the block
    logic [63:0] r_bits;
    logic [5:0]  r_round;
    logic        r_end;        // end of message pending after this block
    logic        r_final;      // this block carries the length
    logic [1:0]  r_part;
    logic [31:0] r_sched [16];
    logic [31:0] w_val, x15, x2, x16, x7, ls0, ls1;
    logic [3:0]  idx;
    logic [255:0] hash;
    sha256_pkg::t_rnd_ctl ctl;
    logic        take;
    logic        out_take;

    assign take     = i_in_valid && !o_in_stall;
    assign out_take = o_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // message schedule ring
    assign idx = r_round[3:0];
    always_comb begin
        x15 = r_sched[idx + 4'd1];
        x2  = r_sched[idx + 4'd14];
        x16 = r_sched[idx];
        x7  = r_sched[idx + 4'd9];
        ls0 = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
        ls1 = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
        w_val = (r_round[5:4] == 2'd0) ? x16 : (x16 + ls0 + x7 + ls1);
    end

    // round unit control
    always_comb begin
        ctl.load  = (r_state == ST_LOAD);
        ctl.step  = (r_state == ST_ROUND);
        ctl.round = r_round;
        ctl.fold  = (r_state == ST_FOLD);
        ctl.init  = out_take && r_part == 2'd3;
    end

    sha256_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_w     (w_val),
        .o_hash  (hash)
    );

    // schedule writes: bytes, padding, length, round expansion
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && take && i_in_data.byte_present) begin
            case (r_cnt[1:0])
                2'd0: r_sched[r_cnt[5:2]] <= {i_in_data.data_byte, 24'h0};
                2'd1: r_sched[r_cnt[5:2]][23:16] <= i_in_data.data_byte;
                2'd2: r_sched[r_cnt[5:2]][15:8]  <= i_in_data.data_byte;
                2'd3: r_sched[r_cnt[5:2]][7:0]   <= i_in_data.data_byte;
                default: ;
            endcase
        end else if (r_state == ST_ROUND) begin
            r_sched[idx] <= w_val;
        end else if (r_state == ST_PAD) begin
            for (int i = 0; i < 16; i++) begin
                if (4'(i) == r_cnt[5:2]) begin
                    case (r_cnt[1:0])
                        2'd0: r_sched[i] <= {sha256_pkg::PAD_BYTE, 24'h0};
                        2'd1: r_sched[i][23:0] <= {sha256_pkg::PAD_BYTE, 16'h0};
                        2'd2: r_sched[i][15:0] <= {sha256_pkg::PAD_BYTE, 8'h0};
                        2'd3: r_sched[i][7:0]  <= sha256_pkg::PAD_BYTE;
                        default: ;
                    endcase
                end else if (4'(i) > r_cnt[5:2]) begin
                    r_sched[i] <= 32'h0;
                end
            end
        end else if (r_state == ST_LEN) begin
            for (int i = 0; i < 14; i++) begin
                if (r_cnt >= sha256_pkg::LEN_OFFSET) r_sched[i] <= 32'h0;
            end
            r_sched[14] <= r_bits[63:32];
            r_sched[15] <= r_bits[31:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (take && i_in_data.byte_present && r_cnt == 6'd63) begin
                    n_state = ST_LOAD;
                end else if (take && i_in_data.end_of_message) begin
                    n_state = ST_PAD;
                end
            end
            ST_LOAD:  n_state = ST_ROUND;
            ST_ROUND: if (r_round == 6'd63) n_state = ST_FOLD;
            ST_FOLD: begin
                if (r_final) n_state = ST_OUT;
                else if (r_end && r_cnt >= sha256_pkg::LEN_OFFSET) n_state = ST_LEN;
                else if (r_end) n_state = ST_PAD;
                else n_state = ST_IDLE;
            end
            ST_PAD: n_state = (r_cnt >= sha256_pkg::LEN_OFFSET) ? ST_LOAD : ST_LEN;
            ST_LEN: n_state = ST_LOAD;
            ST_OUT: if (out_take && r_part == 2'd3) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 6'd0;
            r_bits  <= 64'd0;
            r_round <= 6'd0;
            r_end   <= 1'b0;
            r_final <= 1'b0;
            r_part  <= 2'd0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        r_end <= i_in_data.end_of_message;
                        if (i_in_data.byte_present) begin
                            r_cnt  <= r_cnt + 6'd1;
                            r_bits <= r_bits + 64'd8;
                        end
                    end
                end
                ST_ROUND: r_round <= r_round + 6'd1;
                ST_PAD: begin
                    // two final blocks when the length does not fit
                    if (r_cnt >= sha256_pkg::LEN_OFFSET) begin
                        r_final <= 1'b0;
                    end else begin
                        r_final <= 1'b1;
                    end
                end
                ST_FOLD: begin
                    if (!r_final && r_end && r_cnt >= sha256_pkg::LEN_OFFSET) begin
                        // padding block done, length block next
                        r_final <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_take) begin
                        r_part <= r_part + 2'd1;
                        if (r_part == 2'd3) begin
                            r_cnt   <= 6'd0;
                            r_bits  <= 64'd0;
                            r_end   <= 1'b0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // output word straight from the chained hash
    assign o_out_valid = (r_state == ST_OUT);
    always_comb begin
        o_out_data.digest_part = hash[255 - 64*r_part -: 64];
        o_out_data.part_index  = r_part;
        o_out_data.last_part   = (r_part == 2'd3);
    end

`ifndef ASSERT_OFF
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("input accepted while busy");
    a_round_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_ROUND) |-> (r_round == 6'd0))
        else $error("round counter not back at zero");
    a_last_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && r_part == 2'd3) |=> (r_cnt == 6'd0 && r_bits == 64'd0))
        else $error("message state not cleared after digest");
`endif

endmodule
